// ===== rtl/mdnspa_pkg.sv =====
// Package of the mDNS probe and announce sequencer: transaction structs,
// phase, command and action codes, register indexes and default values.
// Used by mdnspa_core and mdns_probe_announce_sequencer.
package mdnspa_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PROBE_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WAIT_INTERVAL  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ANNOUNCE_GAP   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REANNOUNCE     = 2'd3;

    localparam logic [15:0] DEF_PROBE_MS = 16'd250;
    localparam logic [15:0] DEF_WAIT_MS  = 16'd250;
    localparam logic [15:0] DEF_GAP_MS   = 16'd2000;
    localparam logic [23:0] DEF_REANN_MS = 24'd3600000;

    localparam logic [21:0] STEADY_MIN_MS = 22'd1000;
    localparam logic [21:0] STEADY_MAX_MS = 22'd3600000;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_PROBE1  = 4'd1,
        PH_PROBE2  = 4'd2,
        PH_PROBE3  = 4'd3,
        PH_WAIT    = 4'd4,
        PH_ANN1    = 4'd5,
        PH_ANN2    = 4'd6,
        PH_STEADY  = 4'd7,
        PH_GOODBYE = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_START   = 3'd1,
        CMD_QUERY   = 3'd2,
        CMD_RECORD  = 3'd3,
        CMD_CHANGED = 3'd4,
        CMD_SHUTDN  = 3'd5,
        CMD_REMOVED = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_PROBE    = 3'd1,
        ACT_ANNOUNCE = 3'd2,
        ACT_GOODBYE  = 3'd3,
        ACT_MREPLY   = 3'd4,
        ACT_UREPLY   = 3'd5,
        ACT_SVC_BYE  = 3'd6
    } t_action;

    typedef struct packed {
        logic [2:0] cmd;
        logic       name_matches;
        logic       unicast_requested;
        logic       record_ttl_nonzero;
    } t_in;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  phase;
        logic [1:0]  probe_number;
        logic        conflict_seen;
        logic [21:0] next_timeout_ms;
        logic        no_timeout;
    } t_out;

    typedef struct packed {
        logic [15:0] probe_spacing;
        logic [15:0] settle_span;
        logic [15:0] announce_spacing;
        logic [23:0] reannounce_period_ms;
    } t_cfg;

endpackage

// ===== rtl/mdns_probe_announce_sequencer.sv =====
// Top level of the mDNS probe and announce sequencer: configuration
// registers, input handshake and a two-entry output buffer.
// Depends on mdnspa_pkg and mdnspa_core.
//
// Use: one event (a 1 ms tick or a protocol event) per input transaction,
// one result transaction per event. Each result carries the action to
// take, the phase, the probe count, the conflict flag and the next
// timeout. The result of an accepted transaction is registered. One
// transaction is accepted per cycle while o_in_stall is low; the state
// update is a single combinational pass between the sequencer registers
// and the output register. Configuration is to be written through
// i_cfg_we, i_cfg_index and i_cfg_wdata only while no transaction is
// outstanding; the block does not enforce this. Reset is synchronous
// and active low; it returns the sequencer to idle and the registers to
// their defaults. When the receiver stalls, a second result is held in a
// skid register, and only then does o_in_stall rise; it stays high until
// the edge at which the receiver next takes a result.
module mdns_probe_announce_sequencer #(
    parameter int TIMER_BITS = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  mdnspa_pkg::t_in                         i_in_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output mdnspa_pkg::t_out                        o_out_data,
    input  logic                                    i_cfg_we,
    input  logic [mdnspa_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [mdnspa_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata
);
    import mdnspa_pkg::*;

    t_cfg  r_cfg;
    t_out  r_out_data;
    t_out  r_skid_data;
    logic  r_out_valid;
    logic  r_skid_valid;
    t_out  w_result;
    logic  w_accept;
    logic  w_take;

    assign w_accept = i_in_valid && !r_skid_valid;
    assign w_take   = r_out_valid && !i_out_stall;

    mdnspa_core #(
        .TIMER_BITS(TIMER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.probe_spacing        <= DEF_PROBE_MS;
            r_cfg.settle_span          <= DEF_WAIT_MS;
            r_cfg.announce_spacing     <= DEF_GAP_MS;
            r_cfg.reannounce_period_ms <= DEF_REANN_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PROBE_INTERVAL: r_cfg.probe_spacing        <= i_cfg_wdata[15:0];
                CFG_WAIT_INTERVAL:  r_cfg.settle_span          <= i_cfg_wdata[15:0];
                CFG_ANNOUNCE_GAP:   r_cfg.announce_spacing     <= i_cfg_wdata[15:0];
                CFG_REANNOUNCE:     r_cfg.reannounce_period_ms <= i_cfg_wdata[23:0];
                default:            r_cfg                      <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                if (!r_out_valid || w_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_take) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out_data <= w_result;
            end else begin
                r_skid_data <= w_result;
            end
        end else if (w_take && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Skid register holds a transaction ahead of the output.");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (!r_out_valid || w_take)) |=> (r_out_valid && !r_skid_valid))
        else $error("Accepted transaction did not reach the output register.");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_take) |=> (r_out_valid && !r_skid_valid &&
                                      (r_out_data == $past(r_skid_data))))
        else $error("Skid register did not move to the output.");

endmodule

// ===== rtl/mdnspa_core.sv =====
// Sequencer state of the mDNS probe and announce block: phase, elapsed
// timer, probe count and conflict flag, with the result of each transaction.
// Depends on mdnspa_pkg.
module mdnspa_core #(
    parameter int TIMER_BITS = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  mdnspa_pkg::t_in  i_item,
    input  mdnspa_pkg::t_cfg i_cfg,
    output mdnspa_pkg::t_out o_result
);
    import mdnspa_pkg::*;

    localparam int CW = (TIMER_BITS > 24) ? TIMER_BITS : 24;

    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_elapsed, n_elapsed;
    logic [1:0]            r_count, n_count;
    logic                  r_flag, n_flag;

    logic [TIMER_BITS-1:0] w_elapsed_inc;
    logic [CW-1:0]         w_inc_ext;
    logic                  w_expired;
    logic                  w_answering;
    t_action               w_action;
    logic [21:0]           w_timeout;
    logic                  w_no_timeout;

    function automatic logic [21:0] left_or_one(input logic [CW-1:0] iv,
                                                input logic [CW-1:0] el);
        logic [CW-1:0] d;
        d = iv - el;
        if (el >= iv) begin
            return 22'd1;
        end
        return 22'(d);
    endfunction

    function automatic logic [21:0] steady_left(input logic [CW-1:0] rp,
                                                input logic [CW-1:0] el);
        logic [CW-1:0] d;
        d = rp - el;
        if (el >= rp) begin
            return STEADY_MIN_MS;
        end
        if (d < CW'(STEADY_MIN_MS)) begin
            return STEADY_MIN_MS;
        end
        if (d > CW'(STEADY_MAX_MS)) begin
            return STEADY_MAX_MS;
        end
        return 22'(d);
    endfunction

    always_comb begin
        w_elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
        w_inc_ext     = CW'(w_elapsed_inc);
        w_answering   = (r_phase == PH_ANN1) || (r_phase == PH_ANN2) ||
                        (r_phase == PH_STEADY);
        case (r_phase)
            PH_PROBE1, PH_PROBE2, PH_PROBE3: begin
                w_expired = w_inc_ext >= CW'(i_cfg.probe_spacing);
            end
            PH_WAIT: begin
                w_expired = w_inc_ext >= CW'(i_cfg.settle_span);
            end
            PH_ANN1: begin
                w_expired = w_inc_ext >= CW'(i_cfg.announce_spacing);
            end
            PH_ANN2: begin
                w_expired = 1'b1;
            end
            PH_STEADY: begin
                w_expired = w_inc_ext >= CW'(i_cfg.reannounce_period_ms);
            end
            default: begin
                w_expired = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_count   = r_count;
        n_flag    = r_flag;
        case (i_item.cmd)
            CMD_TICK: begin
                if (r_phase inside {[PH_PROBE1:PH_STEADY]}) begin
                    n_elapsed = w_elapsed_inc;
                    if (w_expired) begin
                        n_elapsed = '0;
                        case (r_phase)
                            PH_PROBE1: begin
                                n_phase = PH_PROBE2;
                                n_count = r_count + 2'd1;
                            end
                            PH_PROBE2: begin
                                n_phase = PH_PROBE3;
                                n_count = r_count + 2'd1;
                            end
                            PH_PROBE3: n_phase = PH_WAIT;
                            PH_WAIT:   n_phase = r_flag ? PH_IDLE : PH_ANN1;
                            PH_ANN1:   n_phase = PH_ANN2;
                            PH_ANN2:   n_phase = PH_STEADY;
                            default:   n_phase = r_phase;
                        endcase
                    end
                end
            end
            CMD_START: begin
                n_phase   = PH_PROBE1;
                n_elapsed = '0;
                n_count   = 2'd1;
                n_flag    = 1'b0;
            end
            CMD_RECORD: begin
                if (r_phase inside {[PH_PROBE1:PH_WAIT]} && i_item.name_matches &&
                    i_item.record_ttl_nonzero) begin
                    n_flag = 1'b1;
                end
            end
            CMD_SHUTDN: begin
                n_phase   = PH_IDLE;
                n_elapsed = '0;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Action of the transaction.
    always_comb begin
        w_action = ACT_NONE;
        case (i_item.cmd)
            CMD_TICK: begin
                if (w_expired) begin
                    case (r_phase)
                        PH_PROBE1, PH_PROBE2: w_action = ACT_PROBE;
                        PH_WAIT:              w_action = r_flag ? ACT_NONE : ACT_ANNOUNCE;
                        PH_ANN1, PH_STEADY:   w_action = ACT_ANNOUNCE;
                        default:              w_action = ACT_NONE;
                    endcase
                end
            end
            CMD_START: w_action = ACT_PROBE;
            CMD_QUERY: begin
                if (w_answering && i_item.name_matches) begin
                    w_action = i_item.unicast_requested ? ACT_UREPLY : ACT_MREPLY;
                end
            end
            CMD_CHANGED: w_action = w_answering ? ACT_ANNOUNCE : ACT_NONE;
            CMD_SHUTDN:  w_action = w_answering ? ACT_GOODBYE : ACT_NONE;
            CMD_REMOVED: w_action = w_answering ? ACT_SVC_BYE : ACT_NONE;
            default:     w_action = ACT_NONE;
        endcase
    end

    // Timeout after the update.
    always_comb begin
        w_no_timeout = 1'b0;
        case (n_phase)
            PH_PROBE1, PH_PROBE2, PH_PROBE3: begin
                w_timeout = left_or_one(CW'(i_cfg.probe_spacing), CW'(n_elapsed));
            end
            PH_WAIT: begin
                w_timeout = left_or_one(CW'(i_cfg.settle_span), CW'(n_elapsed));
            end
            PH_ANN1: begin
                w_timeout = left_or_one(CW'(i_cfg.announce_spacing), CW'(n_elapsed));
            end
            PH_ANN2: begin
                w_timeout = 22'd1;
            end
            PH_STEADY: begin
                w_timeout = steady_left(CW'(i_cfg.reannounce_period_ms), CW'(n_elapsed));
            end
            default: begin
                w_timeout    = '0;
                w_no_timeout = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_count   <= '0;
            r_flag    <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_count   <= n_count;
            r_flag    <= n_flag;
        end
    end

    assign o_result = '{
        action:          w_action,
        phase:           n_phase,
        probe_number:    n_count,
        conflict_seen:   n_flag,
        next_timeout_ms: w_timeout,
        no_timeout:      w_no_timeout
    };

    a_idle_elapsed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_elapsed == '0))
        else $error("Elapsed timer is running in idle.");

    a_probe_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_PROBE1) |-> (r_count == 2'd1)) and
        ((r_phase == PH_PROBE2) |-> (r_count == 2'd2)) and
        ((r_phase == PH_PROBE3) |-> (r_count == 2'd3)))
        else $error("Probe count does not follow the probe phase.");

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_item.cmd == CMD_START)) |=>
        ((r_phase == PH_PROBE1) && (r_count == 2'd1) && !r_flag && (r_elapsed == '0)))
        else $error("Start did not restart probing.");

endmodule
